### hw/rtl/stereo_rms_level_meter_macros.svh
// ----------------------------------------------------------------------------
// Stereo RMS level meter assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_RMS_LEVEL_METER_MACROS_SVH
`define STEREO_RMS_LEVEL_METER_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define SRMS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define SRMS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/srms_pkg.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter package
// Widths, register indexes and shared status type.
// ----------------------------------------------------------------------------
`default_nettype none

package srms_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int HALF_W   = 15;
    localparam int SQ_W     = 29;
    localparam int SUM_W    = 38;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int COEF_W   = 16;
    localparam int LEVEL_W  = 15;
    localparam int FS_W     = 15;
    localparam int SCALED_W = 16;
    localparam int FRAC_W   = 16;

    // Smoothing arithmetic widths
    localparam int PA_W  = LEVEL_W + COEF_W;
    localparam int PB_W  = ROOT_W + COEF_W;
    localparam int ACC_W = PB_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_DECAY      = 2'd0;
    localparam logic [1:0] REG_GAIN       = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [COEF_W-1:0] DECAY_RESET = 16'd60948;
    localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd5898;
    localparam logic [FS_W-1:0]   FS_RESET    = 15'd5571;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

### hw/rtl/srms_lane.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter lane
// Halves one channel sample and registers its square.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_lane
(
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [srms_pkg::SAMPLE_W-1:0] sample,
    output logic             [srms_pkg::SQ_W-1:0]     square
);

    logic signed [srms_pkg::HALF_W-1:0]     half;
    logic signed [2*srms_pkg::HALF_W-1:0]   prod;
    logic        [srms_pkg::SQ_W-1:0]       sq_reg;

    // Halve by arithmetic shift, then square
    assign half = sample[srms_pkg::SAMPLE_W-1:1];
    assign prod = half * half;

    // Hold the square for the merge stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= prod[srms_pkg::SQ_W-1:0];
        end
    end

    assign square = sq_reg;

endmodule

`default_nettype wire

### hw/rtl/srms_divider.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_divider #(
    parameter int DW = 38,
    parameter int VW = 15
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DW-1:0]          dividend,
    input  wire logic [VW-1:0]          divisor,
    output logic [DW-1:0]               quotient,
    output srms_pkg::unit_status_t      status
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   div_reg, div_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [VW:0]     shifted;
    logic [VW:0]     diff;
    logic            fits;

    // Bring down the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNTW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Advance one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### hw/rtl/srms_isqrt.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter square root
// Digit-by-digit integer square root (floor), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_isqrt #(
    parameter int IW = 38
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [IW-1:0]          radicand,
    output logic [IW/2-1:0]             root,
    output srms_pkg::unit_status_t      status
);

    localparam int RTW  = IW / 2;
    localparam int RW   = RTW + 3;
    localparam int CNTW = $clog2(RTW + 1);

    logic [IW-1:0]   val_reg, val_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [RTW-1:0]  root_reg, root_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW-1:0]   rem_s;
    logic [RW-1:0]   trial;
    logic            fits;

    // Bring down two bits and test the next root bit
    assign rem_s = {rem_reg[RW-3:0], val_reg[IW-1:IW-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = rem_s >= trial;

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNTW'(RTW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[IW-3:0], 2'b00};
            rem_next  = fits ? (rem_s - trial) : rem_s;
            root_next = {root_reg[RTW-2:0], fits};
            cnt_next  = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### hw/rtl/stereo_rms_level_meter.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter
// Buffered stereo RMS with exponential smoothing and full-scale mapping.
// ----------------------------------------------------------------------------
// Frames are taken one per cycle while a buffer is open: two lanes halve and
// square the left and right samples, and a merge stage adds both squares into
// a saturating 38-bit sum. A buffer closes on a frame with tlast set or on the
// MAX_FRAMES-th frame. The closing frame then passes through the shared bit-serial
// divider for the mean, the square root unit, the smoothing multiply and sum,
// and the divider again for the scaled level; no frame is taken during that
// time. The result waits in an output register, so the next buffer opens at
// once even if the result has not been taken yet; only when an earlier result
// still occupies that register does the closing frame wait for it to drain.
`default_nettype none

`include "stereo_rms_level_meter_macros.svh"

module stereo_rms_level_meter #(
    parameter int MAX_FRAMES = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Frame input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  wire logic        s_tlast,   // last_frame
    // Level output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [14:0] smoothed_level, [30:15] scaled_level
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [srms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [srms_pkg::DATA_W-1:0] pwdata,
    output logic [srms_pkg::DATA_W-1:0]      prdata,
    output logic             pready
);

    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int DVW   = (CW + 1 > srms_pkg::FS_W) ? CW + 1 : srms_pkg::FS_W;
    localparam int SUMXW = srms_pkg::SUM_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MEAN  = 6'b000010,
        ST_ROOT  = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [srms_pkg::COEF_W-1:0]   decay_coef_reg;
    logic [srms_pkg::COEF_W-1:0]   gain_coef_reg;
    logic [srms_pkg::FS_W-1:0]     full_scale_reg;

    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 pipe_n_reg;
    logic                          pipe_valid_reg;
    logic                          pipe_end_reg;
    logic [srms_pkg::SUM_W-1:0]    square_sum_reg, square_sum_next;
    logic [srms_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic [srms_pkg::PA_W-1:0]     prod_a_reg;
    logic [srms_pkg::PB_W-1:0]     prod_b_reg;
    logic [srms_pkg::SCALED_W-1:0] scaled_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [srms_pkg::LEVEL_W-1:0]  out_level_reg;
    logic [srms_pkg::SCALED_W-1:0] out_scaled_reg;

    logic                          s_accept;
    logic                          end_in;
    logic                          cfg_write;
    logic [srms_pkg::SQ_W-1:0]     sq_l, sq_r;
    logic [SUMXW-1:0]              sum_wide;
    logic [srms_pkg::SUM_W-1:0]    sum_sat;
    logic [srms_pkg::ACC_W-1:0]    acc;
    logic [srms_pkg::LEVEL_W-1:0]  lvl_sat;
    logic [srms_pkg::FS_W-1:0]     fs_eff;
    logic                          load_prod;
    logic                          load_scaled;
    logic                          out_load;

    logic                          div_start;
    logic [srms_pkg::SUM_W-1:0]    div_dividend;
    logic [DVW-1:0]                div_divisor;
    logic [srms_pkg::SUM_W-1:0]    div_quotient;
    srms_pkg::unit_status_t        div_status;
    logic                          sqrt_start;
    logic [srms_pkg::ROOT_W-1:0]   sqrt_root;
    srms_pkg::unit_status_t        sqrt_status;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_coef_reg <= srms_pkg::DECAY_RESET;
            gain_coef_reg  <= srms_pkg::GAIN_RESET;
            full_scale_reg <= srms_pkg::FS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                srms_pkg::REG_DECAY:
                    decay_coef_reg <= pwdata[srms_pkg::COEF_W-1:0];
                srms_pkg::REG_GAIN:
                    gain_coef_reg <= pwdata[srms_pkg::COEF_W-1:0];
                srms_pkg::REG_FULL_SCALE:
                    full_scale_reg <= pwdata[srms_pkg::FS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back a register
    always_comb
    begin
        unique case (paddr[3:2])
            srms_pkg::REG_DECAY:      prdata = srms_pkg::DATA_W'(decay_coef_reg);
            srms_pkg::REG_GAIN:       prdata = srms_pkg::DATA_W'(gain_coef_reg);
            srms_pkg::REG_FULL_SCALE: prdata = srms_pkg::DATA_W'(full_scale_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input handshake and frame count
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE) && !(pipe_valid_reg && pipe_end_reg);
    assign s_accept = s_tvalid && s_tready;
    assign end_in   = s_tlast || (count_reg == CW'(MAX_FRAMES - 1));

    always_comb
    begin
        count_next = count_reg;
        if (s_accept)
        begin
            count_next = end_in ? '0 : count_reg + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Square lanes
    // ------------------------------------------------------------------
    srms_lane u_lane_left (
        .clk    (clk),
        .en     (s_accept),
        .sample (s_tdata[15:0]),
        .square (sq_l)
    );

    srms_lane u_lane_right (
        .clk    (clk),
        .en     (s_accept),
        .sample (s_tdata[31:16]),
        .square (sq_r)
    );

    // ------------------------------------------------------------------
    // Merge both lanes into the saturating sum
    // ------------------------------------------------------------------
    assign sum_wide = SUMXW'(square_sum_reg) + SUMXW'(sq_l) + SUMXW'(sq_r);
    assign sum_sat  = sum_wide[srms_pkg::SUM_W] ? '1 : sum_wide[srms_pkg::SUM_W-1:0];

    always_comb
    begin
        square_sum_next = square_sum_reg;
        if (pipe_valid_reg)
        begin
            square_sum_next = pipe_end_reg ? '0 : sum_sat;
        end
    end

    // ------------------------------------------------------------------
    // Smoothing: round, shift and saturate
    // ------------------------------------------------------------------
    assign acc = srms_pkg::ACC_W'(prod_a_reg) + srms_pkg::ACC_W'(prod_b_reg)
               + srms_pkg::ROUND_HALF;
    assign lvl_sat = (acc[srms_pkg::ACC_W-1:srms_pkg::FRAC_W+srms_pkg::LEVEL_W] != '0)
                   ? srms_pkg::LEVEL_MAX
                   : acc[srms_pkg::FRAC_W+srms_pkg::LEVEL_W-1:srms_pkg::FRAC_W];
    assign fs_eff  = (full_scale_reg == '0) ? srms_pkg::FS_W'(1) : full_scale_reg;

    // ------------------------------------------------------------------
    // Buffer-end sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        div_start     = 1'b0;
        sqrt_start    = 1'b0;
        load_prod     = 1'b0;
        load_scaled   = 1'b0;
        out_load      = 1'b0;
        level_next    = level_reg;
        div_dividend  = sum_sat;
        div_divisor   = DVW'({pipe_n_reg, 1'b0});
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pipe_valid_reg && pipe_end_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_status.done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_status.done)
                begin
                    load_prod  = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                level_next   = lvl_sat;
                div_start    = 1'b1;
                div_dividend = srms_pkg::SUM_W'({lvl_sat, srms_pkg::FRAC_W'(0)});
                div_divisor  = DVW'(fs_eff);
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (div_status.done)
                begin
                    load_scaled = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared divider: mean of squares, then level over full scale
    srms_divider #(
        .DW (srms_pkg::SUM_W),
        .VW (DVW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    srms_isqrt #(
        .IW (srms_pkg::SUM_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quotient),
        .root     (sqrt_root),
        .status   (sqrt_status)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_scaled_reg, out_level_reg};

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_end_reg   <= 1'b0;
            square_sum_reg <= '0;
            level_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pipe_valid_reg <= s_accept;
            if (s_accept)
            begin
                pipe_end_reg <= end_in;
            end
            square_sum_reg <= square_sum_next;
            level_reg      <= level_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pipe_n_reg <= count_reg + CW'(1);
        end
        if (load_prod)
        begin
            prod_a_reg <= srms_pkg::PA_W'(level_reg) * srms_pkg::PA_W'(decay_coef_reg);
            prod_b_reg <= srms_pkg::PB_W'(sqrt_root) * srms_pkg::PB_W'(gain_coef_reg);
        end
        if (load_scaled)
        begin
            scaled_reg <= (div_quotient[srms_pkg::SUM_W-1:srms_pkg::SCALED_W] != '0)
                        ? '1 : div_quotient[srms_pkg::SCALED_W-1:0];
        end
        if (out_load)
        begin
            out_level_reg  <= level_reg;
            out_scaled_reg <= scaled_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRMS_ASSERT_SAME(a_end_blocks_input, clk, rst_n,
        pipe_valid_reg && pipe_end_reg, !s_tready,
        "frame accepted while a buffer end is being merged")

    `SRMS_ASSERT_SAME(a_count_in_range, clk, rst_n,
        1'b1, count_reg < CW'(MAX_FRAMES),
        "frame count reached the buffer limit without closing")

    `SRMS_ASSERT_SAME(a_div_free_on_start, clk, rst_n,
        div_start, !div_status.busy && !sqrt_status.busy,
        "divider started while an iterative unit is busy")

    `SRMS_ASSERT_SAME(a_scaled_follows_level, clk, rst_n,
        m_tvalid && (m_tdata[14:0] != 15'd0), m_tdata[30:15] != 16'd0,
        "nonzero level produced a zero scaled level")

    `SRMS_ASSERT_NEXT(a_result_after_load, clk, rst_n,
        out_load, m_tvalid && (state_reg == ST_IDLE),
        "result load did not present an item and reopen input")

endmodule

`default_nettype wire

### bench/tb_stereo_rms_level_meter.sv
// ----------------------------------------------------------------------------
// Stereo RMS level meter testbench
// Streams stereo frames into the meter, mirrors its buffering, root-mean-square
// and smoothing math in a local level predictor, and checks every emitted
// level item against it across several coefficient settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_stereo_rms_level_meter;

    localparam int FRAMES_PER_BUF = 256;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 1200;
    localparam logic [1:0]  REG_SPARE = 2'd3;
    localparam logic [38:0] SUM_LIMIT = (39'd1 << 38) - 39'd1;

    typedef struct packed {
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic        last_frame;
    } frame_t;

    typedef struct packed {
        logic [srms_pkg::LEVEL_W-1:0]  smoothed_level;
        logic [srms_pkg::SCALED_W-1:0] scaled_level;
    } level_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata = '0;
    logic                         s_tlast = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [31:0]                  m_tdata;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [srms_pkg::ADDR_W-1:0]  paddr = '0;
    logic [srms_pkg::DATA_W-1:0]  pwdata = '0;
    logic [srms_pkg::DATA_W-1:0]  prdata;
    logic                         pready;

    // Pending frames, expected levels and mirrored block state
    frame_t frame_q[$];
    level_t level_q[$];

    logic [srms_pkg::SUM_W-1:0]   sum_sq = '0;
    int                           buf_frames = 0;
    logic [srms_pkg::LEVEL_W-1:0] level_now = '0;
    logic [srms_pkg::COEF_W-1:0]  cfg_decay = srms_pkg::DECAY_RESET;
    logic [srms_pkg::COEF_W-1:0]  cfg_gain = srms_pkg::GAIN_RESET;
    logic [srms_pkg::FS_W-1:0]    cfg_fs = srms_pkg::FS_RESET;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic [7:0] hold_req = '0;
    logic [7:0] hold_ack = '0;
    int   hold_left = 0;
    int   err_cnt = 0;

    stereo_rms_level_meter #(
        .MAX_FRAMES (FRAMES_PER_BUF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Accumulate one frame; on a buffer end, work out the next smoothed and scaled levels
    function automatic void predict_level(input logic signed [15:0] left,
                                          input logic signed [15:0] right,
                                          input logic last);
        logic signed [14:0]         half_l;
        logic signed [14:0]         half_r;
        logic signed [29:0]         sq_l;
        logic signed [29:0]         sq_r;
        logic [38:0]                total;
        logic [srms_pkg::SUM_W-1:0] mean;
        logic [19:0]                root;
        logic [19:0]                trial;
        logic [47:0]                acc;
        logic [31:0]                lvl;
        logic [31:0]                fs;
        logic [31:0]                scaled;
        level_t                     res;
        half_l = 15'(left >>> 1);
        half_r = 15'(right >>> 1);
        sq_l = half_l * half_l;
        sq_r = half_r * half_r;
        total = {1'b0, sum_sq} + 39'(sq_l) + 39'(sq_r);
        if (total > SUM_LIMIT)
        begin
            total = SUM_LIMIT;
        end
        sum_sq = total[srms_pkg::SUM_W-1:0];
        buf_frames++;
        if (!last && buf_frames < FRAMES_PER_BUF)
        begin
            return;
        end
        mean = sum_sq / srms_pkg::SUM_W'(2 * buf_frames);
        // Integer square root, floor, one bit at a time from the top
        root = '0;
        for (int b = 19; b >= 0; b--)
        begin
            trial = root | (20'd1 << b);
            if (40'(trial) * 40'(trial) <= 40'(mean))
            begin
                root = trial;
            end
        end
        acc = 48'(level_now) * 48'(cfg_decay) + 48'(root) * 48'(cfg_gain) + 48'd32768;
        lvl = 32'(acc >> 16);
        if (lvl > 32'(srms_pkg::LEVEL_MAX))
        begin
            lvl = 32'(srms_pkg::LEVEL_MAX);
        end
        fs = (cfg_fs == '0) ? 32'd1 : 32'(cfg_fs);
        scaled = (lvl << 16) / fs;
        if (scaled > 32'hFFFF)
        begin
            scaled = 32'hFFFF;
        end
        level_now = lvl[srms_pkg::LEVEL_W-1:0];
        res.smoothed_level = lvl[srms_pkg::LEVEL_W-1:0];
        res.scaled_level = scaled[srms_pkg::SCALED_W-1:0];
        level_q = {level_q, res};
        sum_sq = '0;
        buf_frames = 0;
    endfunction

    function automatic logic [15:0] rand_sample();
        logic signed [15:0] raw;
        raw = 16'($urandom);
        if ($urandom_range(9) == 0)
        begin
            return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
        end
        return raw >>> $urandom_range(15, 0);
    endfunction

    task automatic push_frame(input logic [15:0] left, input logic [15:0] right,
                              input logic last);
        frame_t f;
        f.left_sample = left;
        f.right_sample = right;
        f.last_frame = last;
        frame_q = {frame_q, f};
    endtask

    // Queue a run of frames: mostly well-formed buffers, some noise
    task automatic gen_frames(input int count, input bit with_long);
        int added;
        int len;
        int kind;
        added = 0;
        if (with_long)
        begin
            // Run past the frame limit so the buffer closes on its own
            len = FRAMES_PER_BUF + $urandom_range(20, 0);
            for (int i = 0; i < len; i++)
            begin
                push_frame(rand_sample(), rand_sample(), 1'b0);
            end
        end
        while (added < count)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                len = $urandom_range(16, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_frame(rand_sample(), rand_sample(), i == len - 1);
                end
            end
            else if (kind < 90)
            begin
                len = $urandom_range(40, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_frame(rand_sample(), rand_sample(), $urandom_range(4) == 0);
                end
            end
            else
            begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_frame(rand_sample(), rand_sample(), 1'b1);
                end
            end
            added += len;
        end
    endtask

    // Two-phase register write; mirror it at the access edge
    task automatic write_reg(input logic [1:0] idx,
                             input logic [srms_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= srms_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            srms_pkg::REG_DECAY:      cfg_decay = value[srms_pkg::COEF_W-1:0];
            srms_pkg::REG_GAIN:       cfg_gain = value[srms_pkg::COEF_W-1:0];
            srms_pkg::REG_FULL_SCALE: cfg_fs = value[srms_pkg::FS_W-1:0];
            default:                  ;
        endcase
    endtask

    // Hold until every frame is taken and every level has come out
    task automatic wait_idle();
        do
            @(posedge clk);
        while (frame_q.size() != 0 || s_tvalid || level_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Frame driver
    always @(posedge clk)
    begin
        frame_t f;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                f = frame_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {f.right_sample, f.left_sample};
                s_tlast <= f.last_frame;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Level receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on every accepted frame
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_level(s_tdata[15:0], s_tdata[31:16], s_tlast);
        end
    end

    // Check every accepted level item against the oldest expectation
    always @(posedge clk)
    begin
        level_t exp_lvl;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (level_q.size() == 0)
            begin
                $display("%0t: unexpected level item: expected none, got smoothed %0d scaled %0d",
                         $time, m_tdata[14:0], m_tdata[30:15]);
                err_cnt++;
            end
            else
            begin
                exp_lvl = level_q.pop_front();
                if (m_tdata[14:0] !== exp_lvl.smoothed_level)
                begin
                    $display("%0t: smoothed_level mismatch: expected %0d, got %0d",
                             $time, exp_lvl.smoothed_level, m_tdata[14:0]);
                    err_cnt++;
                end
                if (m_tdata[30:15] !== exp_lvl.scaled_level)
                begin
                    $display("%0t: scaled_level mismatch: expected %0d, got %0d",
                             $time, exp_lvl.scaled_level, m_tdata[30:15]);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients, no idling: extremes of the samples first
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h7FFF, 16'h7FFF, 1'b1);
        push_frame(16'h0000, 16'h0000, 1'b1);
        push_frame(16'hFFFF, 16'hFFFF, 1'b1);
        push_frame(16'h0001, 16'h0001, 1'b1);
        push_frame(16'h8000, 16'h7FFF, 1'b0);
        push_frame(16'h7FFF, 16'h8000, 1'b1);
        push_frame(16'h5555, 16'hAAAA, 1'b0);
        push_frame(16'hAAAA, 16'h5555, 1'b1);
        push_frame(16'h0000, 16'h8000, 1'b0);
        push_frame(16'h0000, 16'h0000, 1'b0);
        push_frame(16'h0000, 16'h0000, 1'b1);
        // Full buffer of the largest magnitude, closed by the frame limit
        for (int i = 0; i < FRAMES_PER_BUF; i++)
        begin
            push_frame(16'h8000, 16'h8000, 1'b0);
        end
        gen_frames(250, 1'b0);
        wait_idle();

        // Saturating coefficients, zero full scale via masked bits, spare address
        send_idle_pct <= 50;
        write_reg(srms_pkg::REG_DECAY, 32'hABCD_FFFF);
        write_reg(srms_pkg::REG_GAIN, 32'h0000_FFFF);
        write_reg(srms_pkg::REG_FULL_SCALE, 32'hFFFF_8000);
        write_reg(REG_SPARE, 32'h0000_1234);
        gen_frames(250, 1'b0);
        wait_idle();

        // No memory: level follows the rms; widest full scale
        send_idle_pct <= 0;
        recv_stall_pct <= 50;
        write_reg(srms_pkg::REG_DECAY, 32'd0);
        write_reg(srms_pkg::REG_GAIN, 32'd65535);
        write_reg(srms_pkg::REG_FULL_SCALE, 32'd32767);
        gen_frames(250, 1'b0);
        wait_idle();

        // Hold the level, no new input weight, smallest full scale
        send_idle_pct <= 34;
        recv_stall_pct <= 34;
        write_reg(srms_pkg::REG_DECAY, 32'd65535);
        write_reg(srms_pkg::REG_GAIN, 32'd0);
        write_reg(srms_pkg::REG_FULL_SCALE, 32'd1);
        gen_frames(100, 1'b1);
        wait_idle();

        // Random coefficients; hold off the receiver so the input backs up
        send_idle_pct <= 34;
        recv_stall_pct <= 34;
        write_reg(srms_pkg::REG_DECAY, 32'($urandom_range(65535)));
        write_reg(srms_pkg::REG_GAIN, 32'($urandom_range(65535)));
        write_reg(srms_pkg::REG_FULL_SCALE, 32'($urandom_range(32767, 1)));
        gen_frames(100, 1'b1);
        wait_idle();
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        hold_req <= hold_req + 8'd1;
        gen_frames(150, 1'b0);
        wait_idle();

        if (err_cnt == 0 && level_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
